// ----- design/alpha_strip_run_coalescer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the alpha strip run coalescer
// Concurrent assertion wrappers sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ALPHA_STRIP_RUN_COALESCER_CORE_ASSERT_SVH
`define ALPHA_STRIP_RUN_COALESCER_CORE_ASSERT_SVH

// checked outside reset only
`define ASRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked in reset as well
`define ASRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/asrc_pkg.sv -----
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared constants and types of the alpha strip run coalescer.
// ----------------------------------------------------------------------------
package asrc_pkg;

  localparam int MaxRuns   = 16;
  localparam int Lanes     = 8;
  localparam int CoordBits = 12;
  localparam int AlphaBits = 8;
  localparam int ColorBits = 8;
  localparam int SpanBits  = 3;
  localparam int EndBits   = CoordBits + 1;
  localparam int CntW      = $clog2(MaxRuns + 1);
  localparam int IdxW      = (MaxRuns > 1) ? $clog2(MaxRuns) : 1;
  localparam int LaneIdxW  = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam int CfgIdxW   = 2;

  localparam logic ReqUpdate = 1'b0;
  localparam logic ReqFlush  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRed   = 2'd0,
    CfgGreen = 2'd1,
    CfgBlue  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CoordBits-1:0] row;
    logic [AlphaBits-1:0] alpha;
    logic [CoordBits-1:0] x_start;
    logic [EndBits-1:0]   x_end;
  } asrc_run_t;

  typedef struct packed {
    logic             keep;
    logic [Lanes-1:0] hit;
  } asrc_match_t;

endpackage

// ----- design/asrc_ifs.sv -----
// ----------------------------------------------------------------------------
// asrc channel interfaces
// Column requests in, closed runs out, colour register writes.
// ----------------------------------------------------------------------------
interface asrc_in_if;
  import asrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [CoordBits-1:0] column_x;
  logic [CoordBits-1:0] row_first;
  logic [SpanBits-1:0]  row_span;
  logic [AlphaBits-1:0] alpha_lane0;
  logic [AlphaBits-1:0] alpha_lane1;
  logic [AlphaBits-1:0] alpha_lane2;
  logic [AlphaBits-1:0] alpha_lane3;
  logic [AlphaBits-1:0] alpha_lane4;
  logic [AlphaBits-1:0] alpha_lane5;
  logic [AlphaBits-1:0] alpha_lane6;
  logic [AlphaBits-1:0] alpha_lane7;

  modport source (output valid, req_type, column_x, row_first, row_span, alpha_lane0,
                  alpha_lane1, alpha_lane2, alpha_lane3, alpha_lane4, alpha_lane5,
                  alpha_lane6, alpha_lane7, input ready);
  modport sink (input valid, req_type, column_x, row_first, row_span, alpha_lane0,
                alpha_lane1, alpha_lane2, alpha_lane3, alpha_lane4, alpha_lane5,
                alpha_lane6, alpha_lane7, output ready);
endinterface

interface asrc_out_if;
  import asrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] run_x_start;
  logic [EndBits-1:0]   run_x_end;
  logic [CoordBits-1:0] run_row;
  logic [AlphaBits-1:0] run_alpha;
  logic [ColorBits-1:0] run_red;
  logic [ColorBits-1:0] run_green;
  logic [ColorBits-1:0] run_blue;
  logic                 final_run;

  modport source (output valid, run_x_start, run_x_end, run_row, run_alpha, run_red,
                  run_green, run_blue, final_run, input ready);
  modport sink (input valid, run_x_start, run_x_end, run_row, run_alpha, run_red,
                run_green, run_blue, final_run, output ready);
endinterface

interface asrc_cfg_if;
  import asrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [ColorBits-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/asrc_cell.sv -----
// ----------------------------------------------------------------------------
// asrc_cell
// One slot of the open run chain: shifts from its neighbour or loads a run.
// ----------------------------------------------------------------------------
module asrc_cell import asrc_pkg::*; (
  input  logic      clk_i,
  input  logic      shift_i,
  input  asrc_run_t nbr_i,
  input  logic      load_i,
  input  asrc_run_t load_data_i,
  output asrc_run_t run_o
);

  asrc_run_t run_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      run_q <= load_data_i;
    end else if (shift_i) begin
      run_q <= nbr_i;
    end
  end

  assign run_o = run_q;

endmodule

// ----- design/asrc_match.sv -----
// ----------------------------------------------------------------------------
// asrc_match
// Compares the head run against the column lanes: keep flag and lane hits.
// ----------------------------------------------------------------------------
module asrc_match import asrc_pkg::*; (
  input  asrc_run_t                            head_i,
  input  logic [Lanes-1:0][CoordBits-1:0]      lane_row_i,
  input  logic [Lanes-1:0][AlphaBits-1:0]      lane_alpha_i,
  input  logic [Lanes-1:0]                     lane_ok_i,
  output asrc_match_t                          match_o
);

  always_comb begin
    match_o.hit = '0;
    for (int j = 0; j < Lanes; j++) begin
      // lane rows within a column are distinct, so at most one hit
      match_o.hit[j] = lane_ok_i[j] && (lane_row_i[j] == head_i.row) &&
                       (lane_alpha_i[j] == head_i.alpha);
    end
    match_o.keep = |match_o.hit;
  end

endmodule

// ----- design/alpha_strip_run_coalescer_core.sv -----
// ----------------------------------------------------------------------------
// alpha_strip_run_coalescer_core
// Coalesces alpha columns into horizontal runs held in a chain of cells.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  in_if     in   req_type, column_x, row_first, row_span, alpha_lane0..7
//  out_if    out  run_x_start/end, run_row, run_alpha, colour, final_run
//  cfg_if    in   index, data (colour registers)
//
//  Update accepts a column, scans the open runs, drains, then appends lanes;
//  flush skips the append. The scan pops one run a cycle from the chain head;
//  closed runs leave one per cycle, while the output takes them, through a
//  pending stage and the output register. A stalled output holds the scan on
//  the next closing run only. Reset clears the run count, colours and
//  control; cell contents are written before they are read.
// ----------------------------------------------------------------------------
module alpha_strip_run_coalescer_core import asrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  asrc_in_if.sink     in_if,
  asrc_out_if.source  out_if,
  asrc_cfg_if.sink    cfg_if
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDrain,
    StAppend
  } state_e;

  state_e                         state_q;
  logic [CntW-1:0]                count_q;
  logic [CntW-1:0]                rem_q;
  logic                           flush_q;
  logic [Lanes-1:0]               lane_ok_q;
  logic [Lanes-1:0]               hit_q;
  logic [LaneIdxW-1:0]            lane_idx_q;
  logic                           pend_v_q;
  logic                           out_valid_q;
  logic [ColorBits-1:0]           red_q, green_q, blue_q;

  logic [CoordBits-1:0]           x_q;
  logic [Lanes-1:0][CoordBits-1:0] lane_row_q;
  logic [Lanes-1:0][AlphaBits-1:0] lane_alpha_q;
  asrc_run_t                      pend_run_q;
  asrc_run_t                      pend_run_d;
  asrc_run_t                      out_run_q;
  logic                           out_final_q;

  logic [Lanes-1:0][AlphaBits-1:0] alpha_in;
  asrc_run_t                      cell_q [MaxRuns];
  asrc_match_t                    match;
  logic                           in_acc, out_free, pend_move;
  logic                           keep_step, drop_ok, shift_en, app_ok, wr_en;
  logic [IdxW-1:0]                wr_idx;
  asrc_run_t                      wr_data;
  logic [EndBits-1:0]             x_next;

  assign alpha_in[0] = in_if.alpha_lane0;
  assign alpha_in[1] = in_if.alpha_lane1;
  assign alpha_in[2] = in_if.alpha_lane2;
  assign alpha_in[3] = in_if.alpha_lane3;
  assign alpha_in[4] = in_if.alpha_lane4;
  assign alpha_in[5] = in_if.alpha_lane5;
  assign alpha_in[6] = in_if.alpha_lane6;
  assign alpha_in[7] = in_if.alpha_lane7;

  assign in_if.ready  = (state_q == StIdle);
  assign in_acc       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign x_next    = {1'b0, x_q} + EndBits'(1);
  assign out_free  = !out_valid_q || out_if.ready;
  assign keep_step = (flush_q == ReqUpdate) && match.keep;
  // during the scan the pending run only leaves when a later run closes,
  // so the last closed run is always the one sent from the drain state
  assign pend_move = pend_v_q && out_free &&
                     ((state_q == StScan && rem_q != '0 && !keep_step) ||
                      state_q == StDrain);
  assign drop_ok   = !pend_v_q || pend_move;
  assign shift_en  = (state_q == StScan) && (rem_q != '0) && (keep_step || drop_ok);
  assign app_ok    = (state_q == StAppend) && lane_ok_q[lane_idx_q] && !hit_q[lane_idx_q] &&
                     (count_q < CntW'(MaxRuns));
  assign wr_en     = (shift_en && keep_step) || app_ok;

  always_comb begin
    if (state_q == StScan) begin
      // kept run goes to the tail of the remaining chain
      wr_idx          = IdxW'(count_q - CntW'(1));
      wr_data         = cell_q[0];
      wr_data.x_end   = x_next;
    end else begin
      wr_idx          = IdxW'(count_q);
      wr_data.row     = lane_row_q[lane_idx_q];
      wr_data.alpha   = lane_alpha_q[lane_idx_q];
      wr_data.x_start = x_q;
      wr_data.x_end   = x_next;
    end
  end

  always_comb begin
    pend_run_d = cell_q[0];
    if (flush_q == ReqUpdate) pend_run_d.x_end = {1'b0, x_q};
  end

  for (genvar i = 0; i < MaxRuns; i++) begin : g_chain
    asrc_run_t nbr;
    if (i == MaxRuns - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    asrc_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (shift_en),
      .nbr_i       (nbr),
      .load_i      (wr_en && (wr_idx == IdxW'(i))),
      .load_data_i (wr_data),
      .run_o       (cell_q[i])
    );
  end

  asrc_match u_match (
    .head_i       (cell_q[0]),
    .lane_row_i   (lane_row_q),
    .lane_alpha_i (lane_alpha_q),
    .lane_ok_i    (lane_ok_q),
    .match_o      (match)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rem_q       <= '0;
      flush_q     <= 1'b0;
      lane_ok_q   <= '0;
      hit_q       <= '0;
      lane_idx_q  <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CfgRed:   red_q   <= cfg_if.data;
          CfgGreen: green_q <= cfg_if.data;
          CfgBlue:  blue_q  <= cfg_if.data;
          default: ;
        endcase
      end

      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      if (shift_en && !keep_step) begin
        pend_v_q <= 1'b1;
      end else if (pend_move) begin
        pend_v_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            flush_q    <= in_if.req_type;
            rem_q      <= count_q;
            hit_q      <= '0;
            lane_idx_q <= '0;
            for (int i = 0; i < Lanes; i++) begin
              lane_ok_q[i] <= (SpanBits'(i) <= in_if.row_span) && (alpha_in[i] != '0);
            end
            state_q    <= StScan;
          end
        end
        StScan: begin
          if (rem_q == '0) begin
            state_q <= StDrain;
          end else if (shift_en) begin
            rem_q <= rem_q - CntW'(1);
            if (keep_step) begin
              hit_q <= hit_q | match.hit;
            end else begin
              count_q  <= count_q - CntW'(1);
            end
          end
        end
        StDrain: begin
          if (!pend_v_q || pend_move) begin
            state_q <= (flush_q == ReqFlush) ? StIdle : StAppend;
          end
        end
        StAppend: begin
          if (app_ok) count_q <= count_q + CntW'(1);
          lane_idx_q <= lane_idx_q + LaneIdxW'(1);
          if (lane_idx_q == LaneIdxW'(Lanes - 1)) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_if.column_x;
      for (int i = 0; i < Lanes; i++) begin
        lane_row_q[i]   <= in_if.row_first + CoordBits'(i);
        lane_alpha_q[i] <= alpha_in[i];
      end
    end
    if (shift_en && !keep_step) begin
      pend_run_q <= pend_run_d;
    end
    if (pend_move) begin
      out_run_q   <= pend_run_q;
      out_final_q <= (state_q == StDrain);
    end
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.run_x_start = out_run_q.x_start;
  assign out_if.run_x_end   = out_run_q.x_end;
  assign out_if.run_row     = out_run_q.row;
  assign out_if.run_alpha   = out_run_q.alpha;
  assign out_if.run_red     = red_q;
  assign out_if.run_green   = green_q;
  assign out_if.run_blue    = blue_q;
  assign out_if.final_run   = out_final_q;

endmodule

// ----- design/asrc_checker.sv -----
// ----------------------------------------------------------------------------
// asrc_checker
// Port level checks of the run coalescer, bound to the top level.
// ----------------------------------------------------------------------------
`include "alpha_strip_run_coalescer_core_assert.svh"

module asrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_final_i
);

  `ASRC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "output dropped while stalled")
  `ASRC_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_i, "output valid in reset")
  `ASRC_ASSERT(a_busy_after_in, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while busy")
  `ASRC_ASSERT(a_more_pending, out_valid_i && !out_final_i |-> !in_ready_i, "new item before last run")

endmodule

bind alpha_strip_run_coalescer_core asrc_checker u_asrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_final_i (out_if.final_run)
);
